// ===== hdl/ccte_pkg.sv =====
// Package: shared constants and types for the cluster centroid table engine.
`default_nettype none
package ccte_pkg;
    localparam int CLUSTERS_DEF  = 16;
    localparam int FEATURES_DEF  = 16;
    localparam int MAX_COUNT_DEF = 1024;

    localparam logic [1:0] REQ_ACC = 2'd0;
    localparam logic [1:0] REQ_FIN = 2'd1;
    localparam logic [1:0] REQ_SWP = 2'd2;
    localparam logic [1:0] REQ_VAR = 2'd3;

    localparam int DIV_W = 34;  // dividend width, sign-magnitude magnitude bits
    localparam int CNT_W = 11;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num_mag;
        logic              num_neg;
        logic [16:0]       den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic signed [DIV_W:0] quot;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647)
            return 32'h7fffffff;
        else if (v < -35'sd2147483648)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== hdl/ccte_div.sv =====
// Serial restoring divider: signed dividend by positive count, truncating toward zero.
`default_nettype none
module ccte_div
    import ccte_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [17:0]       r_rem, n_rem;
    logic [16:0]       r_den;
    logic              r_neg;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, r_done;
    logic [17:0]       w_trial;

    always_comb begin
        w_trial = {r_rem[16:0], r_quo[DIV_W-1]};
        n_quo   = {r_quo[DIV_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
        n_cnt = r_cnt - STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num_mag;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.num_neg;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule
`default_nettype wire

// ===== hdl/cluster_centroid_table_engine.sv =====
// Top level: center table memory, request sequencer and variance accumulator.
//  channel | dir | handshake          | payload
//  request | in  | i_valid / o_ready  | req_type .. last_flag
//  result  | out | o_valid / i_ready  | center_value, variance_sum, sum_valid
// One item at a time. Finalize takes one pass of the 34-step serial divider,
// swap takes two. After reset a clearing pass writes zero to every table entry,
// one a cycle; no item is taken meanwhile.
// The result waits in an output register; the next item is taken and stalls in
// its last step while that register is still full.
`default_nettype none
module cluster_centroid_table_engine
    import ccte_pkg::*;
#(
    parameter int CLUSTERS  = CLUSTERS_DEF,
    parameter int FEATURES  = FEATURES_DEF,
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [3:0]  i_cluster_one,
    input  wire logic [3:0]  i_cluster_two,
    input  wire logic [3:0]  i_feature_index,
    input  wire logic signed [31:0] i_value_one,
    input  wire logic signed [31:0] i_value_two,
    input  wire logic [10:0] i_count_one,
    input  wire logic [10:0] i_count_two,
    input  wire logic        i_first_flag,
    input  wire logic        i_last_flag,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_center_value,
    output logic [63:0]      o_variance_sum,
    output logic             o_sum_valid
);
    localparam int DEPTH = CLUSTERS * FEATURES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_CALC  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_WRITE = 4'd5;
    localparam logic [3:0] S_VMUL  = 4'd6;
    localparam logic [3:0] S_VADD  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd;
    logic [AW-1:0]      r_clr;
    logic [3:0]         r_state;

    // latched item
    logic [1:0]  r_type;
    logic [3:0]  r_c1, r_c2, r_ft;
    logic signed [31:0] r_v1, r_v2;
    logic [16:0] r_n1, r_n2;
    logic        r_first, r_last;
    logic        r_phase;   // 0 first cluster, 1 second cluster of swap

    logic [63:0] r_sum;
    logic signed [32:0] r_d;
    logic [63:0] r_sq;
    logic signed [31:0] r_newv;
    logic        r_okw;
    logic [AW-1:0] r_addr;
    logic signed [31:0] r_res;
    logic [63:0] r_vout;
    logic        r_sv;
    logic        r_ovalid;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    function automatic logic [16:0] clamp_cnt(input logic [10:0] c);
        if (c == '0) return 17'd1;
        if ({6'd0, c} > 17'(MAX_COUNT)) return 17'(MAX_COUNT);
        return {6'd0, c};
    endfunction

    logic [3:0]  w_cl;
    logic        w_ok;
    logic [AW-1:0] w_addr;
    logic signed [31:0] w_ent;
    logic signed [32:0] w_diff;
    logic [31:0] w_mag;
    logic [64:0] w_add;

    always_comb begin
        w_cl   = r_phase ? r_c2 : r_c1;
        w_ok   = (32'(w_cl) < 32'(CLUSTERS)) && (32'(r_ft) < 32'(FEATURES));
        w_addr = AW'(32'(w_cl) * 32'(FEATURES) + 32'(r_ft));
        w_ent  = r_okw ? r_rd : 32'sd0;
        w_diff = r_phase ? ({r_v1[31], r_v1} - {r_v2[31], r_v2})
                         : ({r_v2[31], r_v2} - {r_v1[31], r_v1});
        // |d| is at most 2^32-1
        w_mag  = r_d[32] ? 32'(-r_d) : 32'(r_d);
        w_add  = {1'b0, r_sum} + {17'd0, r_sq[63:16]};
        w_dreq.start   = 1'b0;
        w_dreq.num_neg = 1'b0;
        w_dreq.num_mag = '0;
        w_dreq.den     = r_phase ? r_n2 : r_n1;
        if (r_state == S_CALC && r_type == REQ_FIN) begin
            w_dreq.start   = 1'b1;
            w_dreq.num_neg = w_ent[31];
            w_dreq.num_mag = DIV_W'(w_ent[31] ? 33'(-{w_ent[31], w_ent})
                                              : 33'({1'b0, w_ent}));
        end else if (r_state == S_CALC && r_type == REQ_SWP) begin
            w_dreq.start   = 1'b1;
            w_dreq.num_neg = w_diff[32];
            w_dreq.num_mag = DIV_W'(w_diff[32] ? 34'(-{w_diff[32], w_diff})
                                               : 34'({1'b0, w_diff}));
        end
    end

    ccte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // memory: one write port, one registered read port
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic signed [31:0] w_wd;
    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = r_newv;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = '0;
        end else if (r_state == S_WRITE) begin
            w_we = r_okw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_addr];
    end

    // result moves to the output register once it is free or being taken
    logic w_load;
    assign w_load = (r_state == S_VADD) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_sum    <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (32'(r_clr) == DEPTH - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_type  <= i_req_type;
                        r_c1    <= i_cluster_one;
                        r_c2    <= i_cluster_two;
                        r_ft    <= i_feature_index;
                        r_v1    <= i_value_one;
                        r_v2    <= i_value_two;
                        r_n1    <= clamp_cnt(i_count_one);
                        r_n2    <= clamp_cnt(i_count_two);
                        r_first <= i_first_flag;
                        r_last  <= i_last_flag;
                        r_phase <= 1'b0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // address presented this cycle; data valid next
                    r_okw   <= w_ok;
                    r_addr  <= w_addr;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    case (r_type)
                        REQ_ACC: begin
                            r_newv  <= sat32(35'(r_first ? 32'sd0 : w_ent) + 35'(r_v1));
                            r_state <= S_WRITE;
                        end
                        REQ_FIN, REQ_SWP: begin
                            r_newv  <= w_ent;
                            r_state <= S_DIV;
                        end
                        default: begin
                            r_d     <= 33'(w_ent) - 33'(r_v1);
                            r_state <= S_VMUL;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        if (r_type == REQ_FIN)
                            r_newv <= 32'(w_drsp.quot);
                        else
                            r_newv <= sat32(35'(r_newv) + 35'(w_drsp.quot));
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_type == REQ_SWP && !r_phase) begin
                        r_phase <= 1'b1;
                        r_state <= S_READ;
                    end else begin
                        r_phase <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_VMUL: begin
                    r_sq    <= 64'(w_mag) * 64'(w_mag);
                    r_state <= S_VADD;
                end
                S_VADD: begin
                    // non-variance results carry a zero sum
                    if (w_load) begin
                        if (r_type == REQ_VAR) begin
                            r_vout <= w_add[64] ? '1 : w_add[63:0];
                            r_sum  <= r_last ? 64'd0 : (w_add[64] ? '1 : w_add[63:0]);
                            r_sv   <= r_last;
                        end else begin
                            r_vout <= '0;
                            r_sv   <= 1'b0;
                        end
                        r_res   <= w_ent;
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    // re-read first cluster entry for the result
                    r_state <= S_VADD;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_FIN) begin
                r_okw <= w_ok;
            end
            if (w_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_center_value = r_res;
    assign o_variance_sum = r_vout;
    assign o_sum_valid    = r_sv;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_center_value)
            && $stable(o_variance_sum) && $stable(o_sum_valid)))
        else $error("result changed while waiting");
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sum_valid) |-> (r_sum == 64'd0)) else $error("sum not cleared");
    a_no_write_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_valid || !o_ready) else $error("accept in clear");
`endif
endmodule
`default_nettype wire
